// File: hw/rtl/dats_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Daily alarm table scheduler package
// Field widths, operation and status codes, the table entry layout and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package dats_pkg;

    localparam int OP_W          = 3;
    localparam int IDX_FIELD_W   = 4;
    localparam int HOUR_W        = 5;
    localparam int MIN_W         = 6;
    localparam int DAY_W         = 3;
    localparam int STATUS_W      = 2;
    localparam int COUNT_FIELD_W = 5;
    localparam int TOTAL_W       = 11;
    localparam int DIST_W        = 13;
    localparam int BEST_W        = 14;

    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD     = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE  = 3'd2;
    localparam logic [OP_W-1:0] OP_ENABLE  = 3'd3;
    localparam logic [OP_W-1:0] OP_DISABLE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

    localparam logic [TOTAL_W-1:0] MINUTES_PER_HOUR = 11'd60;
    localparam logic [DIST_W-1:0]  MINUTES_PER_DAY  = 13'd1440;
    localparam logic [BEST_W-1:0]  NO_DISTANCE      = 14'd9999;
    localparam logic [DAY_W-1:0]   NEVER_DAY        = 3'd7;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic              enabled;
        logic [DAY_W-1:0]  last_day;
    } entry_t;

    typedef struct packed {
        logic load;
        logic add_entry;
        logic flag_full;
        logic flag_bad;
        logic rd_chosen;
        logic rd_index;
        logic ptr_from_index;
        logic rd_next;
        logic wr_shift;
        logic count_down;
        logic fire_check;
        logic wr_enable;
        logic scan_init;
        logic scan_issue;
        logic result_load;
    } dats_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic is_add;
        logic is_remove;
        logic is_toggle;
        logic table_full;
        logic index_bad;
        logic tick_live;
        logic shift_more;
        logic scan_more;
        logic out_busy;
    } dats_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/dats_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Daily alarm table scheduler channels
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface dats_req_if;
    import dats_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        operation;
    logic [IDX_FIELD_W-1:0] event_index;
    logic [HOUR_W-1:0]      new_hour;
    logic [MIN_W-1:0]       new_minute;
    logic                   new_enabled;
    logic [HOUR_W-1:0]      now_hour;
    logic [MIN_W-1:0]       now_minute;
    logic [DAY_W-1:0]       now_weekday;

    modport source (
        output valid, operation, event_index, new_hour, new_minute, new_enabled,
               now_hour, now_minute, now_weekday,
        input  ready
    );
    modport sink (
        input  valid, operation, event_index, new_hour, new_minute, new_enabled,
               now_hour, now_minute, now_weekday,
        output ready
    );
endinterface

interface dats_rsp_if;
    import dats_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic                     fired;
    logic [IDX_FIELD_W-1:0]   fired_index;
    logic                     next_valid;
    logic [IDX_FIELD_W-1:0]   next_index;
    logic [COUNT_FIELD_W-1:0] event_count;

    modport source (
        output valid, status, fired, fired_index, next_valid, next_index, event_count,
        input  ready
    );
    modport sink (
        input  valid, status, fired, fired_index, next_valid, next_index, event_count,
        output ready
    );
endinterface
`default_nettype wire

// File: hw/rtl/dats_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Daily alarm table scheduler controller
// Sequences each operation: decode, table update, reselection scan and
// hand-over of the result to the output register.
// ----------------------------------------------------------------------------
module dats_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire dats_pkg::dats_stat_t stat,
    output dats_pkg::dats_cmd_t       cmd
);
    import dats_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_TICK_CHK  = 4'd2;
    localparam logic [3:0] S_EN_WR     = 4'd3;
    localparam logic [3:0] S_SHIFT_CHK = 4'd4;
    localparam logic [3:0] S_SHIFT_WR  = 4'd5;
    localparam logic [3:0] S_SCAN_INIT = 4'd6;
    localparam logic [3:0] S_SCAN      = 4'd7;
    localparam logic [3:0] S_SCAN_END  = 4'd8;
    localparam logic [3:0] S_DONE      = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_SCAN_INIT;
                if (stat.is_tick)
                begin
                    if (stat.tick_live)
                    begin
                        cmd.rd_chosen = 1'b1;
                        state_next    = S_TICK_CHK;
                    end
                end
                else if (stat.is_add)
                begin
                    if (stat.table_full)
                    begin
                        cmd.flag_full = 1'b1;
                    end
                    else
                    begin
                        cmd.add_entry = 1'b1;
                    end
                end
                else if (stat.is_remove || stat.is_toggle)
                begin
                    if (stat.index_bad)
                    begin
                        cmd.flag_bad = 1'b1;
                    end
                    else if (stat.is_remove)
                    begin
                        cmd.ptr_from_index = 1'b1;
                        state_next         = S_SHIFT_CHK;
                    end
                    else
                    begin
                        cmd.rd_index = 1'b1;
                        state_next   = S_EN_WR;
                    end
                end
            end
            S_TICK_CHK:
            begin
                cmd.fire_check = 1'b1;
                state_next     = S_SCAN_INIT;
            end
            S_EN_WR:
            begin
                cmd.wr_enable = 1'b1;
                state_next    = S_SCAN_INIT;
            end
            S_SHIFT_CHK:
            begin
                if (stat.shift_more)
                begin
                    cmd.rd_next = 1'b1;
                    state_next  = S_SHIFT_WR;
                end
                else
                begin
                    cmd.count_down = 1'b1;
                    state_next     = S_SCAN_INIT;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                state_next   = S_SHIFT_CHK;
            end
            S_SCAN_INIT:
            begin
                cmd.scan_init = 1'b1;
                state_next    = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.scan_more)
                begin
                    cmd.scan_issue = 1'b1;
                end
                else
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/dats_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Daily alarm table scheduler datapath
// Alarm table memory, entry count, shift and scan pointer, distance compare
// for reselection, fire check and the output register.
// ----------------------------------------------------------------------------
module dats_datapath #(
    parameter int MAX_ALARMS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire dats_pkg::dats_cmd_t                 cmd,
    output dats_pkg::dats_stat_t                     stat,
    input  wire logic [dats_pkg::OP_W-1:0]           operation,
    input  wire logic [dats_pkg::IDX_FIELD_W-1:0]    event_index,
    input  wire logic [dats_pkg::HOUR_W-1:0]         new_hour,
    input  wire logic [dats_pkg::MIN_W-1:0]          new_minute,
    input  wire logic                                new_enabled,
    input  wire logic [dats_pkg::HOUR_W-1:0]         now_hour,
    input  wire logic [dats_pkg::MIN_W-1:0]          now_minute,
    input  wire logic [dats_pkg::DAY_W-1:0]          now_weekday,
    dats_rsp_if.source                               rsp
);
    import dats_pkg::*;

    localparam int IDX_W = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
    localparam int CNT_W = $clog2(MAX_ALARMS + 1);
    localparam int CMP_W = (CNT_W > IDX_FIELD_W) ? CNT_W : IDX_FIELD_W;

    entry_t mem [MAX_ALARMS];

    logic [OP_W-1:0]        op_reg;
    logic [IDX_FIELD_W-1:0] idx_reg;
    entry_t                 new_entry_reg;
    logic [HOUR_W-1:0]      now_hour_reg;
    logic [MIN_W-1:0]       now_minute_reg;
    logic [DAY_W-1:0]       weekday_reg;
    logic [TOTAL_W-1:0]     now_total_reg;

    logic [CNT_W-1:0]       used_reg;
    logic                   chosen_valid_reg;
    logic [IDX_W-1:0]       chosen_entry_reg;
    logic [BEST_W-1:0]      best_reg;
    logic [CNT_W-1:0]       ptr_reg;
    logic                   eval_valid_reg;
    logic [IDX_W-1:0]       eval_idx_reg;
    entry_t                 rd_data_reg;
    logic [STATUS_W-1:0]    res_status_reg;
    logic                   fired_reg;
    logic [IDX_W-1:0]       fired_idx_reg;

    logic                     out_valid_reg;
    logic [STATUS_W-1:0]      out_status_reg;
    logic                     out_fired_reg;
    logic [IDX_FIELD_W-1:0]   out_fired_idx_reg;
    logic                     out_next_valid_reg;
    logic [IDX_FIELD_W-1:0]   out_next_idx_reg;
    logic [COUNT_FIELD_W-1:0] out_count_reg;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [CNT_W:0]   ptr_wide_inc;
    logic             fire_hit;
    logic [TOTAL_W-1:0] entry_total;
    logic [DIST_W-1:0]  wrap_add;
    logic [DIST_W-1:0]  fwd_dist;
    logic               cand;

    // Status towards the controller.
    assign ptr_wide_inc = {1'b0, ptr_reg} + (CNT_W + 1)'(1);

    always_comb
    begin
        stat            = '0;
        stat.is_tick    = (op_reg == OP_TICK);
        stat.is_add     = (op_reg == OP_ADD);
        stat.is_remove  = (op_reg == OP_DELETE);
        stat.is_toggle  = (op_reg == OP_ENABLE) || (op_reg == OP_DISABLE);
        stat.table_full = (used_reg == CNT_W'(MAX_ALARMS));
        stat.index_bad  = (CMP_W'(idx_reg) >= CMP_W'(used_reg));
        stat.tick_live  = chosen_valid_reg && (CNT_W'(chosen_entry_reg) < used_reg);
        stat.shift_more = (ptr_wide_inc < {1'b0, used_reg});
        stat.scan_more  = (ptr_reg < used_reg);
        stat.out_busy   = out_valid_reg && !rsp.ready;
    end

    // The fire test and the distance both look at the entry just read.
    assign fire_hit = (rd_data_reg.hour == now_hour_reg)
                   && (rd_data_reg.minute == now_minute_reg)
                   && (rd_data_reg.last_day != weekday_reg)
                   && rd_data_reg.enabled;

    always_comb
    begin
        entry_total = {{(TOTAL_W - HOUR_W){1'b0}}, rd_data_reg.hour} * MINUTES_PER_HOUR
                    + {{(TOTAL_W - MIN_W){1'b0}}, rd_data_reg.minute};
        wrap_add    = (entry_total > now_total_reg) ? '0 : MINUTES_PER_DAY;
        fwd_dist    = {2'b00, entry_total} + wrap_add - {2'b00, now_total_reg};
        cand        = eval_valid_reg && rd_data_reg.enabled && !fwd_dist[DIST_W-1]
                   && (fwd_dist != '0) && ({1'b0, fwd_dist} < best_reg);
    end

    // Table port selection.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rd_data_reg;
        if (cmd.add_entry)
        begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(used_reg);
            wr_data = new_entry_reg;
        end
        else if (cmd.wr_shift)
        begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(ptr_reg);
        end
        else if (cmd.wr_enable)
        begin
            wr_en           = 1'b1;
            wr_addr         = IDX_W'(idx_reg);
            wr_data.enabled = (op_reg == OP_ENABLE);
        end
        else if (cmd.fire_check && fire_hit)
        begin
            wr_en            = 1'b1;
            wr_addr          = chosen_entry_reg;
            wr_data.last_day = weekday_reg;
        end
    end

    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = '0;
        if (cmd.rd_chosen)
        begin
            rd_addr = chosen_entry_reg;
        end
        else if (cmd.rd_index)
        begin
            rd_addr = IDX_W'(idx_reg);
        end
        else if (cmd.rd_next)
        begin
            rd_addr = IDX_W'(ptr_wide_inc);
        end
        else if (cmd.scan_issue)
        begin
            rd_addr = IDX_W'(ptr_reg);
        end
        else
        begin
            rd_en = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Request fields and working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg                 <= operation;
            idx_reg                <= event_index;
            new_entry_reg.hour     <= new_hour;
            new_entry_reg.minute   <= new_minute;
            new_entry_reg.enabled  <= new_enabled;
            new_entry_reg.last_day <= NEVER_DAY;
            now_hour_reg           <= now_hour;
            now_minute_reg         <= now_minute;
            weekday_reg            <= now_weekday;
            now_total_reg          <= {{(TOTAL_W - HOUR_W){1'b0}}, now_hour} * MINUTES_PER_HOUR
                                    + {{(TOTAL_W - MIN_W){1'b0}}, now_minute};
            res_status_reg         <= ST_OK;
            fired_reg              <= 1'b0;
            fired_idx_reg          <= '0;
        end
        if (cmd.flag_full)
        begin
            res_status_reg <= ST_FULL;
        end
        if (cmd.flag_bad)
        begin
            res_status_reg <= ST_BAD_INDEX;
        end
        if (cmd.fire_check && fire_hit)
        begin
            fired_reg     <= 1'b1;
            fired_idx_reg <= chosen_entry_reg;
        end
        if (cmd.ptr_from_index)
        begin
            ptr_reg <= CNT_W'(idx_reg);
        end
        else if (cmd.scan_init)
        begin
            ptr_reg <= '0;
        end
        else if (cmd.wr_shift || cmd.scan_issue)
        begin
            ptr_reg <= ptr_wide_inc[CNT_W-1:0];
        end
        if (cmd.scan_issue)
        begin
            eval_idx_reg <= IDX_W'(ptr_reg);
        end
        if (cmd.scan_init)
        begin
            best_reg <= NO_DISTANCE;
        end
        else if (cand)
        begin
            best_reg <= {1'b0, fwd_dist};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg         <= '0;
            chosen_valid_reg <= 1'b0;
            chosen_entry_reg <= '0;
            eval_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.add_entry)
            begin
                used_reg <= used_reg + CNT_W'(1);
            end
            else if (cmd.count_down)
            begin
                used_reg <= used_reg - CNT_W'(1);
            end
            eval_valid_reg <= cmd.scan_issue;
            if (cmd.scan_init)
            begin
                chosen_valid_reg <= 1'b0;
                chosen_entry_reg <= '0;
            end
            else if (cand)
            begin
                chosen_valid_reg <= 1'b1;
                chosen_entry_reg <= eval_idx_reg;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            out_status_reg     <= res_status_reg;
            out_fired_reg      <= fired_reg;
            out_fired_idx_reg  <= fired_reg ? IDX_FIELD_W'(fired_idx_reg) : '0;
            out_next_valid_reg <= chosen_valid_reg;
            out_next_idx_reg   <= chosen_valid_reg ? IDX_FIELD_W'(chosen_entry_reg) : '0;
            out_count_reg      <= COUNT_FIELD_W'(used_reg);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.fired       = out_fired_reg;
    assign rsp.fired_index = out_fired_idx_reg;
    assign rsp.next_valid  = out_next_valid_reg;
    assign rsp.next_index  = out_next_idx_reg;
    assign rsp.event_count = out_count_reg;

endmodule
`default_nettype wire

// File: hw/rtl/daily_alarm_table_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Daily alarm table scheduler
// Table of daily alarms with add, delete, enable, disable and minute tick,
// choosing the nearest enabled alarm after every operation.
// ----------------------------------------------------------------------------
//  Channel  Role  Carries
//  req      sink  operation, event_index, new alarm fields, current time
//  rsp      src   status, fired, fired_index, next_valid, next_index, count
//
// A result is ready after the reselection scan, which reads one entry a
// cycle; a live tick, an enable or a disable first reads and may write one
// entry, and a delete first moves each entry above the deleted one down.
// After reset the table is empty; there is no clearing pass.
// A request is taken while a result waits in the output register, and the
// next result is held until that one has been transferred.
module daily_alarm_table_scheduler #(
    parameter int MAX_ALARMS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    dats_req_if.sink   req,
    dats_rsp_if.source rsp
);
    import dats_pkg::*;

    dats_cmd_t  cmd;
    dats_stat_t stat;

    dats_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dats_datapath #(
        .MAX_ALARMS (MAX_ALARMS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .operation   (req.operation),
        .event_index (req.event_index),
        .new_hour    (req.new_hour),
        .new_minute  (req.new_minute),
        .new_enabled (req.new_enabled),
        .now_hour    (req.now_hour),
        .now_minute  (req.now_minute),
        .now_weekday (req.now_weekday),
        .rsp         (rsp)
    );

endmodule
`default_nettype wire

// File: hw/rtl/dats_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Daily alarm table scheduler checker
// Port-level properties of the scheduler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module dats_checker #(
    parameter int MAX_ALARMS
) (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 req_valid,
    input wire logic                                 req_ready,
    input wire logic                                 rsp_valid,
    input wire logic                                 rsp_ready,
    input wire logic [dats_pkg::STATUS_W-1:0]        status,
    input wire logic                                 fired,
    input wire logic [dats_pkg::IDX_FIELD_W-1:0]     fired_index,
    input wire logic                                 next_valid,
    input wire logic [dats_pkg::IDX_FIELD_W-1:0]     next_index,
    input wire logic [dats_pkg::COUNT_FIELD_W-1:0]   event_count
);
    import dats_pkg::*;

    // A stalled result holds until it is transferred.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(fired)
            && $stable(fired_index) && $stable(next_valid) && $stable(next_index)
            && $stable(event_count))
        else $error("response changed while stalled");

    // One request is worked on at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in progress");

    // A fire is reported only with the OK status.
    a_fire_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && fired |-> status == ST_OK)
        else $error("fire reported with error status");

    // The chosen entry lies inside the table.
    a_next_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && next_valid && (MAX_ALARMS <= 16)
            |-> {1'b0, next_index} < event_count)
        else $error("next alarm outside the table");

endmodule

bind daily_alarm_table_scheduler dats_checker #(
    .MAX_ALARMS (MAX_ALARMS)
) u_dats_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .fired       (rsp.fired),
    .fired_index (rsp.fired_index),
    .next_valid  (rsp.next_valid),
    .next_index  (rsp.next_index),
    .event_count (rsp.event_count)
);
`default_nettype wire
